### hdl/tkoh_pkg.sv
// Package for the top-K outlier heap: widths, opcodes, slot layout.
// No dependencies.
package tkoh_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam logic [15:0] THRESH_RESET = 16'd768;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [24:0] dlt;
    logic [23:0] smp;
    logic [7:0]  chan;
    logic [31:0] ts;
    logic [15:0] sigma;
  } slot_t;
endpackage

### hdl/tkoh_div.sv
// Serial restoring divider for sigma = (|delta| << 8) / stddev, one bit a cycle.
// Depends on tkoh_pkg.
module tkoh_div
  import tkoh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [15:0] sigma
);
  logic [32:0] quo_r, quo_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [25:0] trial;
  logic [24:0] shifted;

  always_comb begin
    shifted = {rem_r[23:0], quo_r[32]};
    trial = {1'b0, shifted} - {2'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[25]) begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[31:0], 1'b0};
      end else begin
        rem_nxt = trial[24:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  // Quotient at completion is quo_nxt; saturate to 16 bits.
  assign sigma = (quo_nxt[32:16] != '0) ? 16'hFFFF : quo_nxt[15:0];
endmodule

### hdl/tkoh_ram.sv
// Slot memory of the heap: one write port, one registered read port.
// Depends on tkoh_pkg.
module tkoh_ram
  import tkoh_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  slot_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output slot_t            rdata
);
  slot_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/top_k_outlier_heap.sv
// Top-K outlier heap: min-heap on sigma over a slot memory with one write and one read port.
// Result path to out_tvalid: an offer runs the serial divide, then up to four sift
// levels through the slot memory; an offer with zero stddev and a clear go there
// directly, and a read waits for the registered memory read.
// One request at a time; the next can be taken in the cycle after the result handshake.
// Reset (synchronous, rst_n low) empties the heap and sets the threshold to 3.0.
// Depends on tkoh_pkg, tkoh_div, tkoh_ram.
module top_k_outlier_heap
  import tkoh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], timestamp_ms[33:2], channel[41:34], sample[65:42],
  // mean[89:66], stddev[113:90], read_index[117:114]
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted[0], entry_count[5:1], entry_valid[6], entry_timestamp_ms[38:7],
  // entry_channel[46:39], entry_sample[70:47], entry_delta[95:71],
  // entry_sigma[111:96]
  output logic [111:0] out_tdata
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV   = 10'b0000000010,
    S_ROOT  = 10'b0000000100,
    S_UPRD  = 10'b0000001000,
    S_UPCMP = 10'b0000010000,
    S_DNL   = 10'b0000100000,
    S_DNR   = 10'b0001000000,
    S_DNCMP = 10'b0010000000,
    S_RDW   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] thr_r;
  logic [CNT_W-1:0] total_r, total_nxt;
  slot_t new_r, new_nxt, lch_r, lch_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt, read_idx_r;
  logic [7:0] dn_l, dn_r;
  logic [111:0] res_r, res_nxt;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  slot_t wdata, rdata;

  logic div_start, div_done;
  logic [15:0] div_sigma;
  logic signed [24:0] delta;
  logic [24:0] mag;

  opcode_t op;
  assign op = opcode_t'(in_tdata[1:0]);
  assign delta = {in_tdata[65], in_tdata[65:42]} - {in_tdata[89], in_tdata[89:66]};
  assign mag = delta[24] ? (25'd0 - delta) : delta;

  tkoh_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({mag, 8'd0}), .divisor(in_tdata[113:90]),
    .done(div_done), .sigma(div_sigma)
  );

  tkoh_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = res_r;

  // Children of pos_r; 8 bits so that the bound check sees the full value.
  assign dn_l = {4'd0, pos_r} * 8'd2 + 8'd1;
  assign dn_r = {4'd0, pos_r} * 8'd2 + 8'd2;

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    new_nxt = new_r;
    lch_nxt = lch_r;
    pos_nxt = pos_r;
    res_nxt = res_r;
    we = 1'b0;
    waddr = pos_r;
    wdata = new_r;
    raddr = pos_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt = '0;
          unique case (op)
            OP_OFFER: begin
              new_nxt.ts = in_tdata[33:2];
              new_nxt.chan = in_tdata[41:34];
              new_nxt.smp = in_tdata[65:42];
              new_nxt.dlt = delta;
              if (in_tdata[113:90] == '0) begin
                state_nxt = S_OUT;
                res_nxt[5:1] = total_r;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_CLEAR: begin
              total_nxt = '0;
              res_nxt[5:1] = '0;
              state_nxt = S_OUT;
            end
            OP_READ: begin
              raddr = in_tdata[117:114];
              state_nxt = S_RDW;
            end
            OP_NONE: begin
              res_nxt[5:1] = total_r;
              state_nxt = S_OUT;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          new_nxt.sigma = div_sigma;
          if (div_sigma < thr_r) begin
            res_nxt[5:1] = total_r;
            state_nxt = S_OUT;
          end else if (total_r < CNT_W'(CAPACITY)) begin
            pos_nxt = total_r[IDX_W-1:0];
            total_nxt = total_r + 1'b1;
            state_nxt = S_UPRD;
          end else begin
            raddr = '0;
            state_nxt = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (new_r.sigma <= rdata.sigma) begin
          res_nxt[5:1] = total_r;
          state_nxt = S_OUT;
        end else begin
          pos_nxt = '0;
          // Left child of the root.
          raddr = IDX_W'(1);
          state_nxt = S_DNL;
        end
      end
      // Sift-up keeps the new entry in new_r and writes it once it settles.
      S_UPRD: begin
        if (pos_r == '0) begin
          we = 1'b1;
          res_nxt[5:1] = total_r;
          res_nxt[0] = 1'b1;
          state_nxt = S_OUT;
        end else begin
          raddr = (pos_r - 1'b1) >> 1;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (new_r.sigma < rdata.sigma) begin
          we = 1'b1;
          wdata = rdata;
          pos_nxt = (pos_r - 1'b1) >> 1;
          state_nxt = S_UPRD;
        end else begin
          we = 1'b1;
          res_nxt[5:1] = total_r;
          res_nxt[0] = 1'b1;
          state_nxt = S_OUT;
        end
      end
      // Sift-down: left child read issued; on arrival issue the right read.
      S_DNL: begin
        if (dn_l >= {3'd0, total_r}) begin
          we = 1'b1;
          res_nxt[5:1] = total_r;
          res_nxt[0] = 1'b1;
          state_nxt = S_OUT;
        end else begin
          lch_nxt = rdata;
          raddr = dn_r[IDX_W-1:0];
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        state_nxt = S_DNCMP;
        raddr = dn_l[IDX_W-1:0];
        priority if (dn_r < {3'd0, total_r} && rdata.sigma < lch_r.sigma
                     && rdata.sigma < new_r.sigma) begin
          we = 1'b1;
          wdata = rdata;
          pos_nxt = dn_r[IDX_W-1:0];
        end else if (lch_r.sigma < new_r.sigma) begin
          we = 1'b1;
          wdata = lch_r;
          pos_nxt = dn_l[IDX_W-1:0];
        end else begin
          we = 1'b1;
          res_nxt[5:1] = total_r;
          res_nxt[0] = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DNCMP: begin
        // Issue the read of the new left child from the updated position.
        raddr = dn_l[IDX_W-1:0];
        state_nxt = S_DNL;
      end
      S_RDW: begin
        if ({1'b0, read_idx_r} < total_r) begin
          res_nxt[6] = 1'b1;
          res_nxt[38:7] = rdata.ts;
          res_nxt[46:39] = rdata.chan;
          res_nxt[70:47] = rdata.smp;
          res_nxt[95:71] = rdata.dlt;
          res_nxt[111:96] = rdata.sigma;
        end
        res_nxt[5:1] = total_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      thr_r <= THRESH_RESET;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
    end
    new_r <= new_nxt;
    lch_r <= lch_nxt;
    pos_r <= pos_nxt;
    res_r <= res_nxt;
    if (in_tready && in_tvalid) read_idx_r <= in_tdata[117:114];
  end
endmodule

### tb/tkoh_checker.sv
// Checker for the top-K outlier heap: watches the request and result streams,
// keeps its own heap image and compares each result word in full.
// Depends on tkoh_pkg.
`timescale 1ns / 100ps
module tkoh_checker
  import tkoh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  slot_t       heap_img [CAPACITY];
  int          heap_fill;
  logic [15:0] thresh;
  logic [111:0] result_q [$];

  assign pending = result_q.size();

  function automatic void swap_img(int a, int b);
    slot_t t;
    t = heap_img[a];
    heap_img[a] = heap_img[b];
    heap_img[b] = t;
  endfunction

  function automatic logic offer_sample(logic [119:0] d);
    logic signed [24:0] dl;
    logic [24:0] mag;
    logic [23:0] sd;
    logic [63:0] q;
    slot_t s;
    int i, p, l, r, m;
    sd = d[113:90];
    if (sd == 0) return 1'b0;
    dl = $signed({d[65], d[65:42]}) - $signed({d[89], d[89:66]});
    mag = dl[24] ? -dl : dl;
    q = {31'd0, mag, 8'd0} / {40'd0, sd};
    if (q > 64'd65535) q = 64'd65535;
    if (q[15:0] < thresh) return 1'b0;
    s.sigma = q[15:0];
    s.ts = d[33:2];
    s.chan = d[41:34];
    s.smp = d[65:42];
    s.dlt = dl;
    if (heap_fill < CAPACITY) begin
      i = heap_fill;
      heap_img[i] = s;
      heap_fill++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (heap_img[i].sigma < heap_img[p].sigma) begin
          swap_img(i, p);
          i = p;
        end else break;
      end
      return 1'b1;
    end
    if (s.sigma <= heap_img[0].sigma) return 1'b0;
    heap_img[0] = s;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      m = i;
      if (l < heap_fill && heap_img[l].sigma < heap_img[m].sigma) m = l;
      if (r < heap_fill && heap_img[r].sigma < heap_img[m].sigma) m = r;
      if (m == i) break;
      swap_img(i, m);
      i = m;
    end
    return 1'b1;
  endfunction

  function automatic logic [111:0] heap_result(logic [119:0] d);
    logic [111:0] o;
    opcode_t op;
    int idx;
    o = '0;
    op = opcode_t'(d[1:0]);
    idx = d[117:114];
    case (op)
      OP_OFFER: o[0] = offer_sample(d);
      OP_CLEAR: heap_fill = 0;
      OP_READ: begin
        if (idx < heap_fill) begin
          o[6] = 1'b1;
          o[38:7] = heap_img[idx].ts;
          o[46:39] = heap_img[idx].chan;
          o[70:47] = heap_img[idx].smp;
          o[95:71] = heap_img[idx].dlt;
          o[111:96] = heap_img[idx].sigma;
        end
      end
      default: ;
    endcase
    o[5:1] = heap_fill[4:0];
    return o;
  endfunction

  always @(posedge clk) begin
    logic [111:0] want;
    if (!rst_n) begin
      heap_fill = 0;
      thresh = THRESH_RESET;
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (cfg_we) thresh = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (want !== out_tdata) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) result_q.push_back(heap_result(in_tdata));
    end
  end
endmodule

### tb/tb_top.sv
// Testbench top for the top-K outlier heap: clock, reset, stimulus and verdict.
// Depends on tkoh_pkg, top_k_outlier_heap and tkoh_checker.
`timescale 1ns / 100ps
module tb_top;
  import tkoh_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic in_tvalid, in_tready;
  logic [119:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [111:0] out_tdata;
  int fail_count, pending;
  int cycle_cnt;
  bit hold_off;

  top_k_outlier_heap uut (.*);
  tkoh_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 600000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall per request, with one long hold-off on demand.
  initial begin
    int w;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  // in_tvalid stays high after the handshake; callers that pause drop it.
  task automatic send_req(opcode_t op, logic [31:0] ts, logic [7:0] ch,
                          logic [23:0] smp, logic [23:0] mean, logic [23:0] sd,
                          logic [3:0] idx);
    int w;
    w = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tdata <= {2'b00, idx, sd, mean, smp, ch, ts, op};
    in_tvalid <= 1;
    @(posedge clk iff in_tready);
  endtask

  task automatic set_thresh(logic [15:0] v);
    in_tvalid <= 0;
    @(posedge clk iff pending == 0);
    repeat (80) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Mostly a moderate spread so sigma lands near typical thresholds.
  task automatic rand_offer();
    logic [23:0] sd, mean, smp;
    mean = 24'($urandom);
    case ($urandom_range(0, 5))
      0: sd = 24'($urandom);
      1: sd = 0;
      default: sd = 24'($urandom_range(1, 256));
    endcase
    smp = ($urandom_range(0, 4) == 0) ? 24'($urandom) : mean + 24'($urandom_range(0, 4000)) -
          24'd2000;
    send_req(OP_OFFER, $urandom, 8'($urandom), smp, mean, sd, 4'($urandom));
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cycle_cnt = 0;
    hold_off = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: extremes, zero stddev, ties, every opcode, reads out of range.
    send_req(OP_READ, 0, 0, 0, 0, 0, 4'd0);
    send_req(OP_OFFER, 32'hFFFF_FFFF, 8'hFF, 24'h7FFFFF, 24'h800000, 24'd1, 4'hF);
    send_req(OP_OFFER, 0, 0, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 0);
    send_req(OP_OFFER, 1, 1, 24'd5000, 0, 24'd0, 0);
    send_req(OP_OFFER, 2, 2, 24'd768, 0, 24'd256, 0);
    send_req(OP_OFFER, 3, 3, 24'hFFFD00, 0, 24'd256, 0);
    send_req(OP_OFFER, 4, 4, 24'd767, 0, 24'd256, 0);
    send_req(OP_NONE, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'hF);
    for (int i = 0; i < 4; i++) send_req(OP_READ, 0, 0, 0, 0, 0, i[3:0]);
    send_req(OP_READ, 0, 0, 0, 0, 0, 4'hF);
    send_req(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_req(OP_READ, 0, 0, 0, 0, 0, 4'd0);
    set_thresh(16'd0);
    // Fill to capacity with equal sigmas, then a tie with the root.
    for (int i = 0; i < 17; i++)
      send_req(OP_OFFER, i, i[7:0], 24'd1024, 0, 24'd256, 0);
    send_req(OP_OFFER, 99, 9, 24'd2048, 0, 24'd256, 0);
    for (int i = 0; i < 16; i++) send_req(OP_READ, 0, 0, 0, 0, 0, i[3:0]);
    set_thresh(16'hFFFF);
    send_req(OP_OFFER, 7, 7, 24'h7FFFFF, 24'h800000, 24'd1, 0);
    send_req(OP_OFFER, 8, 8, 24'd100, 0, 24'd256, 0);
    // Random phases over several threshold settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_thresh(16'd768);
        1: set_thresh(16'd0);
        2: set_thresh(16'($urandom_range(0, 4096)));
        3: set_thresh(16'd2000);
        default: set_thresh(16'($urandom));
      endcase
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 19))
          0: send_req(OP_CLEAR, $urandom, 8'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 4'($urandom));
          1: send_req(OP_NONE, $urandom, 8'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 4'($urandom));
          2, 3, 4, 5: send_req(OP_READ, $urandom, 8'($urandom), 24'($urandom),
                               24'($urandom), 24'($urandom), 4'($urandom));
          default: rand_offer();
        endcase
      end
    end
    in_tvalid <= 0;
    @(posedge clk iff pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

### sim.f
hdl/tkoh_pkg.sv
hdl/tkoh_div.sv
hdl/tkoh_ram.sv
hdl/top_k_outlier_heap.sv
tb/tkoh_checker.sv
tb/tb_top.sv
